// File: src/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/tdmd_pkg.sv
`default_nettype none
package tdmd_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int FQ_DEPTH_DEF = 2;

  localparam int WORD_W    = 32;
  localparam int TAG_W     = 4;
  localparam int TAG_LSB   = 8;
  localparam int SAMPLE_W  = 16;
  localparam int SAMPLE_LSB = 16;
  localparam int CHAN_W    = 3;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] word;
  } tdmd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic                       last_of_frame;
  } tdmd_out_t;

endpackage
`default_nettype wire

// File: src/tdmd_front.sv
`default_nettype none
module tdmd_front #(
  parameter int CHANNELS = tdmd_pkg::CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  input  wire tdmd_pkg::tdmd_in_t                  in_data,
  input  wire logic                                fq_full_i,
  output logic                                     full,
  output logic                                     fq_push_o,
  output logic [CHANNELS*tdmd_pkg::SAMPLE_W-1:0]   fq_data_o
);
  import tdmd_pkg::*;

  localparam int SLOT_W = $clog2(CHANNELS);

  logic                 aligned_r, aligned_nxt;
  logic [TAG_W-1:0]     exp_tag_r, exp_tag_nxt;
  logic [SLOT_W-1:0]    wif_r, wif_nxt;
  logic [SAMPLE_W-1:0]  slots_r [CHANNELS];
  logic [SAMPLE_W-1:0]  slots_nxt [CHANNELS];

  logic                 accept;
  logic [TAG_W-1:0]     tag;
  logic [SAMPLE_W-1:0]  smp;
  logic                 wr_en;
  logic                 emit;

  assign full   = fq_full_i;
  assign accept = push && !fq_full_i;
  assign tag    = in_data.word[TAG_LSB +: TAG_W];
  assign smp    = in_data.word[SAMPLE_LSB +: SAMPLE_W];

  always_comb begin
    aligned_nxt = aligned_r;
    exp_tag_nxt = exp_tag_r;
    wif_nxt     = wif_r;
    wr_en       = 1'b0;
    emit        = 1'b0;
    if (accept) begin
      if (in_data.command) begin
        aligned_nxt = 1'b0;
        exp_tag_nxt = '0;
        wif_nxt     = '0;
      end else if (!aligned_r) begin
        if (tag == exp_tag_r) begin
          wr_en = 1'b1;
          if (exp_tag_r == TAG_W'(CHANNELS - 1)) begin
            aligned_nxt = 1'b1;
            exp_tag_nxt = '0;
            wif_nxt     = '0;
            emit        = 1'b1;
          end else begin
            exp_tag_nxt = exp_tag_r + TAG_W'(1);
          end
        end else if (tag == '0) begin
          wr_en       = 1'b1;
          exp_tag_nxt = TAG_W'(1);
        end else begin
          exp_tag_nxt = '0;
        end
      end else begin
        wr_en = 1'b1;
        if (wif_r == SLOT_W'(CHANNELS - 1)) begin
          wif_nxt = '0;
          emit    = 1'b1;
        end else begin
          wif_nxt = wif_r + SLOT_W'(1);
        end
      end
    end
  end

  // out-of-range tags match no slot and are dropped
  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      slots_nxt[k] = (wr_en && tag == TAG_W'(k)) ? smp : slots_r[k];
      fq_data_o[k*SAMPLE_W +: SAMPLE_W] = slots_nxt[k];
    end
  end

  assign fq_push_o = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aligned_r <= 1'b0;
      exp_tag_r <= '0;
      wif_r     <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        slots_r[k] <= '0;
      end
    end else begin
      aligned_r <= aligned_nxt;
      exp_tag_r <= exp_tag_nxt;
      wif_r     <= wif_nxt;
      for (int k = 0; k < CHANNELS; k++) begin
        slots_r[k] <= slots_nxt[k];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/tdmd_frame_fifo.sv
`default_nettype none
`include "assert_macros.svh"
module tdmd_frame_fifo #(
  parameter int DEPTH = tdmd_pkg::FQ_DEPTH_DEF,
  parameter int WIDTH = tdmd_pkg::CHANNELS_DEF * tdmd_pkg::SAMPLE_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o
);
  import tdmd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign valid_o = (cnt_r != '0);
  assign data_o  = mem[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_NEVER(a_cnt_bound, cnt_r > CNT_W'(DEPTH), "frame queue count above depth")
  `ASSERT_PROP(a_no_push_full, push_i |-> !full_o, "frame pushed into full queue")

endmodule
`default_nettype wire

// File: src/tdmd_back.sv
`default_nettype none
`include "assert_macros.svh"
module tdmd_back #(
  parameter int CHANNELS = tdmd_pkg::CHANNELS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   fq_valid_i,
  input  wire logic [CHANNELS*tdmd_pkg::SAMPLE_W-1:0] fq_data_i,
  output logic                                        fq_pop_o,
  output logic                                        empty,
  input  wire logic                                   pop,
  output tdmd_pkg::tdmd_out_t                         out_data
);
  import tdmd_pkg::*;

  localparam int SLOT_W = $clog2(CHANNELS);

  logic [CHANNELS*SAMPLE_W-1:0] frame_r, frame_nxt;
  logic                         have_r, have_nxt;
  logic [SLOT_W-1:0]            idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tdmd_out_t                    out_r, out_nxt;

  logic load_ok, last_beat, take;

  assign load_ok   = !out_valid_r || pop;
  assign last_beat = have_r && (idx_r == SLOT_W'(CHANNELS - 1));
  assign take      = fq_valid_i && (!have_r || (load_ok && last_beat));
  assign fq_pop_o  = take;
  assign empty     = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    frame_nxt     = frame_r;
    have_nxt      = have_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (load_ok) begin
      out_valid_nxt = have_r;
      if (have_r) begin
        out_nxt.sample        = frame_r[idx_r*SAMPLE_W +: SAMPLE_W];
        out_nxt.channel       = CHAN_W'(idx_r);
        out_nxt.last_of_frame = last_beat;
        idx_nxt               = idx_r + SLOT_W'(1);
        if (last_beat) begin
          have_nxt = 1'b0;
        end
      end
    end
    if (take) begin
      frame_nxt = fq_data_i;
      have_nxt  = 1'b1;
      idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      have_r      <= have_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEVER(a_idx_range, have_r && (idx_r > SLOT_W'(CHANNELS - 1)),
    "slot index past last channel")

endmodule
`default_nettype wire

// File: src/tagged_tdm_channel_deinterleaver.sv
// tagged tdm channel deinterleaver
// input queue side: push/full with in_data {command, word}; a beat is taken
// when push is high and full is low. command 1 restarts the alignment hunt.
// result queue side: empty/pop with out_data {sample, channel, last_of_frame};
// the oldest result is shown while empty is low and leaves when pop is high.
// a front stage tracks the hunt and the slot registers, one word per cycle
// while full is low; each completed frame is copied into a frame queue
// (FQ_DEPTH entries); a back stage reads one frame out as CHANNELS beats, one
// per cycle while the receiver keeps popping, through an output register.
// path: the first sample of a frame reaches the ports through the frame queue,
// the back stage's frame register and the output register; throughput is one
// word in and, on average, one sample out per cycle when neither side stalls.
// if the receiver stalls, the output register and frame queue fill and then
// full rises, stalling the sender; nothing is dropped.
// synchronous reset (rst_n low) clears the hunt, all slots to zero and all
// queued results.
`default_nettype none
module tagged_tdm_channel_deinterleaver #(
  parameter int CHANNELS = tdmd_pkg::CHANNELS_DEF,
  parameter int FQ_DEPTH = tdmd_pkg::FQ_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire tdmd_pkg::tdmd_in_t  in_data,
  output logic                     empty,
  input  wire logic                pop,
  output tdmd_pkg::tdmd_out_t      out_data
);
  import tdmd_pkg::*;

  localparam int FW = CHANNELS * SAMPLE_W;

  logic          fq_push, fq_full, fq_valid, fq_pop;
  logic [FW-1:0] fq_wdata, fq_rdata;

  tdmd_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .fq_full_i (fq_full),
    .full      (full),
    .fq_push_o (fq_push),
    .fq_data_o (fq_wdata)
  );

  tdmd_frame_fifo #(.DEPTH(FQ_DEPTH), .WIDTH(FW)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fq_push),
    .data_i  (fq_wdata),
    .full_o  (fq_full),
    .valid_o (fq_valid),
    .pop_i   (fq_pop),
    .data_o  (fq_rdata)
  );

  tdmd_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fq_valid_i (fq_valid),
    .fq_data_i  (fq_rdata),
    .fq_pop_o   (fq_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: test/tb_tagged_tdm_channel_deinterleaver.sv
module tb_tagged_tdm_channel_deinterleaver;
  timeunit 1ns;
  timeprecision 1ps;

  import tdmd_pkg::*;

  localparam int CHANNELS = CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  tdmd_in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  tdmd_out_t out_data;

  tagged_tdm_channel_deinterleaver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // hunt and slot state of the deinterleaver as predicted
  logic locked = 1'b0;
  logic [3:0] hunt_tag = '0;
  logic [3:0] word_cnt = '0;
  logic signed [SAMPLE_W-1:0] slot_val [CHANNELS];

  tdmd_in_t words_to_send[$];
  tdmd_out_t samples_due[$];
  tdmd_out_t want;

  int n_sent = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  logic in_fire = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int pop_mode = 0;
  int mode_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < CHANNELS; k++) slot_val[k] = '0;
  end

  function automatic void emit_slots();
    tdmd_out_t r;
    for (int k = 0; k < CHANNELS; k++) begin
      r.sample = slot_val[k];
      r.channel = CHAN_W'(k);
      r.last_of_frame = (k == CHANNELS - 1);
      samples_due.push_back(r);
    end
  endfunction

  function automatic void deinterleave_word(tdmd_in_t b);
    logic [TAG_W-1:0] tag;
    logic signed [SAMPLE_W-1:0] smp;
    tag = b.word[TAG_LSB +: TAG_W];
    smp = b.word[SAMPLE_LSB +: SAMPLE_W];
    if (b.command) begin
      locked = 1'b0;
      hunt_tag = '0;
      word_cnt = '0;
      return;
    end
    if (!locked) begin
      if (tag == hunt_tag) begin
        if (tag < CHANNELS) slot_val[tag] = smp;
        hunt_tag = hunt_tag + 1'b1;
        if (hunt_tag >= CHANNELS) begin
          locked = 1'b1;
          hunt_tag = '0;
          word_cnt = '0;
          emit_slots();
        end
      end else if (tag == 0) begin
        slot_val[0] = smp;
        hunt_tag = 4'd1;
      end else begin
        hunt_tag = '0;
      end
    end else begin
      if (tag < CHANNELS) slot_val[tag] = smp;
      word_cnt = word_cnt + 1'b1;
      if (word_cnt >= CHANNELS) begin
        word_cnt = '0;
        emit_slots();
      end
    end
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want_v,
                                      logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  // input side acceptance, prediction and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = push && !full;
      if (in_fire) begin
        deinterleave_word(in_data);
        if (words_to_send.size() != 0) words_to_send.delete(0);
      end
      if (pop && !empty) begin
        if (samples_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual sample %0d channel %0d last %0d",
                   $time, out_data.sample, out_data.channel, out_data.last_of_frame);
          mismatch_cnt++;
        end else begin
          want = samples_due.pop_front();
          check_field("sample", want.sample, out_data.sample);
          check_field("channel", want.channel, out_data.channel);
          check_field("last_of_frame", want.last_of_frame, out_data.last_of_frame);
        end
      end
    end
  end

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !in_fire) begin
      // hold the beat until it is taken
    end else if (gap_left != 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (words_to_send.size() != 0) begin
      push <= 1'b1;
      in_data <= words_to_send[0];
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end
    end else begin
      push <= 1'b0;
    end
  end

  // receiver: stall pattern changes at random intervals, long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats still expected", $time, samples_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic tdmd_in_t data_beat(logic [15:0] smp, logic [3:0] tag, logic [11:0] fill);
    tdmd_in_t b;
    b.command = 1'b0;
    b.word = {smp, fill[11:8], tag, fill[7:0]};
    return b;
  endfunction

  function automatic tdmd_in_t restart_beat(logic [31:0] junk);
    tdmd_in_t b;
    b.command = 1'b1;
    b.word = junk;
    return b;
  endfunction

  task automatic send(tdmd_in_t b);
    words_to_send.push_back(b);
    n_sent++;
  endtask

  task automatic send_rand(logic [3:0] tag);
    send(data_beat(16'($urandom), tag, 12'($urandom)));
  endtask

  task automatic add_sync();
    send(restart_beat($urandom));
    for (int t = 0; t < CHANNELS; t++) send_rand(4'(t));
  endtask

  // in order, shuffled, or arbitrary tags including out-of-range ones
  task automatic add_frame();
    logic [3:0] order [CHANNELS];
    logic [3:0] tmp;
    int j;
    int style;
    style = $urandom_range(0, 2);
    for (int t = 0; t < CHANNELS; t++) order[t] = 4'(t);
    if (style == 1) begin
      for (int t = CHANNELS - 1; t > 0; t--) begin
        j = $urandom_range(0, t);
        tmp = order[t];
        order[t] = order[j];
        order[j] = tmp;
      end
    end
    for (int t = 0; t < CHANNELS; t++) begin
      send_rand((style == 2) ? 4'($urandom) : order[t]);
    end
  endtask

  task automatic add_random(int upto);
    int pick;
    int k;
    while (n_sent < upto) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        add_sync();
        repeat ($urandom_range(1, 4)) add_frame();
      end else if (pick < 8) begin
        add_frame();
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) send(restart_beat($urandom));
          else send_rand(4'($urandom));
        end
      end else begin
        // hunt broken part way through
        send(restart_beat($urandom));
        k = $urandom_range(1, CHANNELS - 2);
        for (int t = 0; t < k; t++) send_rand(4'(t));
        send_rand(4'($urandom_range(1, 15)));
      end
    end
  endtask

  task automatic drain();
    while (words_to_send.size() != 0 || samples_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(restart_beat(32'hFFFF_FFFF));
    send(data_beat(16'h1234, 4'd0, 12'h000));
    send(data_beat(16'h2345, 4'd1, 12'hFFF));
    send(data_beat(16'h3456, 4'd3, 12'h000));
    send(data_beat(16'h4567, 4'd5, 12'hFFF));
    send(data_beat(16'h0001, 4'd0, 12'h000));
    send(data_beat(16'h8000, 4'd0, 12'hFFF));
    send(data_beat(16'h7FFF, 4'd1, 12'h000));
    send(data_beat(16'hFFFF, 4'd2, 12'hFFF));
    send(data_beat(16'h0000, 4'd3, 12'h000));
    send(data_beat(16'h8001, 4'd4, 12'hFFF));
    send(data_beat(16'h7FFE, 4'd5, 12'h000));
    send(data_beat(16'h00FF, 4'd6, 12'hFFF));
    send(data_beat(16'hFF00, 4'd7, 12'h000));
    // duplicates, dropped tags and slots left unwritten
    send(data_beat(16'hAAAA, 4'd3, 12'hFFF));
    send(data_beat(16'h5555, 4'd3, 12'h000));
    send(data_beat(16'hDEAD, 4'd15, 12'hFFF));
    send(data_beat(16'hBEEF, 4'd8, 12'h000));
    send(data_beat(16'hFFFF, 4'd0, 12'hFFF));
    send(data_beat(16'h8000, 4'd7, 12'h000));
    send(data_beat(16'hCAFE, 4'd12, 12'hFFF));
    send(data_beat(16'h7FFF, 4'd1, 12'h000));
    // restart in the middle of a frame
    send(data_beat(16'h1111, 4'd5, 12'hFFF));
    send(data_beat(16'h2222, 4'd6, 12'h000));
    send(restart_beat(32'h0000_0000));
    drain();

    add_random(n_sent + 65);

    @(posedge clk);
    hold_req = 1'b1;
    add_sync();
    repeat (6) add_frame();
    drain();

    add_random(n_sent + 65);
    drain();

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
